// ===== rtl/spe_pkg.sv =====
// Shared types and constants for the SEI payload extractor.
`timescale 1ns / 1ps
package spe_pkg;

  localparam int SPE_SIZE_BITS  = 24;
  localparam int SPE_MAX_RES    = 3;
  localparam int SPE_FIFO_DEPTH = 4;
  localparam int SPE_CFG_IDX_W  = 1;
  localparam int SPE_CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [SPE_CFG_IDX_W-1:0] REG_WANTED_TYPE = 1'd0;
  localparam logic [SPE_CFG_IDX_W-1:0] REG_HEVC_MODE   = 1'd1;

  localparam logic [15:0] WANTED_TYPE_RST = 16'd4;

  // Byte codes
  localparam logic [7:0] BYTE_EPB  = 8'h03;
  localparam logic [7:0] BYTE_STOP = 8'h80;
  localparam logic [7:0] BYTE_FF   = 8'hFF;

  // NAL unit types
  localparam logic [4:0] AVC_TYPE_SEI       = 5'd6;
  localparam logic [5:0] HEVC_TYPE_SEI_PRE  = 6'd39;
  localparam logic [5:0] HEVC_TYPE_SEI_SUFX = 6'd40;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_SIZE = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       nal_end;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       payload_start;
    logic       payload_end;
    logic       truncated;
  } out_t;

  typedef struct packed {
    logic [15:0] wanted_type;
    logic        hevc_mode;
  } cfg_t;

  // Results produced by one word, written into the output queue at once
  typedef struct packed {
    logic [1:0]                 cnt;
    out_t [SPE_MAX_RES-1:0]     res;
  } push_t;

endpackage

// ===== rtl/spe_parser.sv =====
// Header check, emulation-prevention removal and SEI message parsing for one word.
`timescale 1ns / 1ps
module spe_parser
  import spe_pkg::*;
#(
  parameter int SIZE_BITS = SPE_SIZE_BITS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_go,
  input  in_t   item,
  output push_t push
);

  typedef struct packed {
    logic                 at_start;
    logic                 is_sei;
    logic [1:0]           hdr_left;
    logic [1:0]           zero_run;
    logic                 held_three;
    phase_t               phase;
    logic [15:0]          type_sum;
    logic [SIZE_BITS-1:0] size_left;
    logic                 type_match;
    logic                 body_started;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic emit;
    out_t res;
  } step_t;

  localparam pst_t PST_CLEAR = '{
    at_start:     1'b1,
    is_sei:       1'b0,
    hdr_left:     2'd0,
    zero_run:     2'd0,
    held_three:   1'b0,
    phase:        PH_TYPE,
    type_sum:     16'd0,
    size_left:    '0,
    type_match:   1'b0,
    body_started: 1'b0
  };

  // One byte through the type / size / body parse
  function automatic step_t parse_step(pst_t s, logic [7:0] b, logic last,
                                       logic [15:0] want);
    step_t                r;
    logic [16:0]          tsum;
    logic [SIZE_BITS:0]   ssum;
    logic [SIZE_BITS-1:0] snew;
    logic [SIZE_BITS-1:0] sdec;
    r      = '0;
    r.st   = s;
    tsum   = {1'b0, s.type_sum} + 17'(b);
    ssum   = {1'b0, s.size_left} + (SIZE_BITS+1)'(b);
    snew   = ssum[SIZE_BITS] ? '1 : ssum[SIZE_BITS-1:0];
    sdec   = s.size_left - SIZE_BITS'(1);
    unique case (s.phase)
      PH_TYPE: begin
        // final 0x80 of the unit at a message start is the trailing bits
        if (!(b == BYTE_STOP && last && s.type_sum == 16'd0)) begin
          r.st.type_sum = tsum[16] ? 16'hFFFF : tsum[15:0];
          if (b != BYTE_FF) begin
            r.st.phase     = PH_SIZE;
            r.st.size_left = '0;
          end
        end
      end
      PH_SIZE: begin
        r.st.size_left = snew;
        if (b != BYTE_FF) begin
          if (snew == '0) begin
            r.st.phase    = PH_TYPE;
            r.st.type_sum = 16'd0;
          end else begin
            r.st.phase        = PH_BODY;
            r.st.type_match   = (s.type_sum == want);
            r.st.body_started = 1'b0;
          end
        end
      end
      PH_BODY: begin
        r.st.size_left = sdec;
        if (s.type_match) begin
          r.emit              = 1'b1;
          r.res.data_byte     = b;
          r.res.data_valid    = 1'b1;
          r.res.payload_start = !s.body_started;
          r.res.payload_end   = (sdec == '0);
          r.res.truncated     = 1'b0;
        end
        r.st.body_started = 1'b1;
        if (sdec == '0) begin
          r.st.phase        = PH_TYPE;
          r.st.type_sum     = 16'd0;
          r.st.body_started = 1'b0;
          r.st.type_match   = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  pst_t       st_r;
  pst_t       st_nxt;
  pst_t       st_a;
  step_t      stp_a;
  step_t      stp_b;
  logic [7:0] b;
  logic       last;
  logic [5:0] hevc_type;
  logic       trunc;
  logic [1:0] cnt;
  out_t       marker;
  out_t [SPE_MAX_RES-1:0] res;

  assign b         = item.nal_byte;
  assign last      = item.nal_end;
  assign hevc_type = b[6:1];

  always_comb begin
    st_a  = st_r;
    stp_a = '0;
    stp_b = '0;
    if (st_r.at_start) begin
      st_a.at_start = 1'b0;
      if (cfg.hevc_mode) begin
        st_a.is_sei   = (hevc_type == HEVC_TYPE_SEI_PRE) ||
                        (hevc_type == HEVC_TYPE_SEI_SUFX);
        st_a.hdr_left = 2'd1;
      end else begin
        st_a.is_sei   = (b[4:0] == AVC_TYPE_SEI);
        st_a.hdr_left = 2'd0;
      end
    end else if (!st_r.is_sei) begin
      // drop the rest of a non-SEI unit
    end else if (st_r.hdr_left != 2'd0) begin
      st_a.hdr_left = st_r.hdr_left - 2'd1;
    end else begin
      // release or drop a held 0x03 depending on the byte after it
      if (st_a.held_three) begin
        st_a.held_three = 1'b0;
        if (b > BYTE_EPB) begin
          stp_a = parse_step(st_a, BYTE_EPB, 1'b0, cfg.wanted_type);
          st_a  = stp_a.st;
        end
        st_a.zero_run = 2'd0;
      end
      if (st_a.zero_run[1] && b == BYTE_EPB && !last) begin
        st_a.held_three = 1'b1;
      end else begin
        stp_b = parse_step(st_a, b, last, cfg.wanted_type);
        st_a  = stp_b.st;
        if (b == 8'd0) begin
          st_a.zero_run = st_a.zero_run[1] ? 2'd2 : st_a.zero_run + 2'd1;
        end else begin
          st_a.zero_run = 2'd0;
        end
      end
    end
  end

  always_comb begin
    marker               = '0;
    marker.payload_start = 1'b1;
    marker.payload_end   = 1'b1;
    marker.truncated     = 1'b1;
    cnt    = 2'({1'b0, stp_a.emit} + {1'b0, stp_b.emit});
    res[0] = stp_a.emit ? stp_a.res : stp_b.res;
    res[1] = stp_b.res;
    res[2] = '0;
    trunc  = last && st_a.is_sei && st_a.phase == PH_BODY && st_a.type_match &&
             st_a.size_left != '0;
    if (trunc) begin
      if (st_a.body_started && cnt != 2'd0) begin
        // mark the last body word of this unit as cut short
        if (cnt == 2'd2) begin
          res[1].payload_end = 1'b1;
          res[1].truncated   = 1'b1;
        end else begin
          res[0].payload_end = 1'b1;
          res[0].truncated   = 1'b1;
        end
      end else begin
        unique case (cnt)
          2'd0:    res[0] = marker;
          2'd1:    res[1] = marker;
          default: res[2] = marker;
        endcase
        cnt = cnt + 2'd1;
      end
    end
    st_nxt = last ? PST_CLEAR : st_a;
  end

  assign push.cnt = item_go ? cnt : 2'd0;
  assign push.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PST_CLEAR;
    end else if (item_go) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/spe_out_fifo.sv =====
// Result queue: takes up to three results a cycle, hands out one while out_stall is low.
`timescale 1ns / 1ps
module spe_out_fifo
  import spe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_payload
);

  localparam int PTR_W = $clog2(SPE_FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  out_t             mem [SPE_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] left;
  logic             pop;

  assign out_valid   = (count_r != '0);
  assign out_payload = mem[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  assign left        = count_r - CNT_W'(pop);
  // a word may only enter when all of its results fit
  assign room        = (left <= CNT_W'(SPE_FIFO_DEPTH - SPE_MAX_RES));
  assign count_nxt   = left + CNT_W'(push.cnt);

  always_ff @(posedge clk) begin
    for (int i = 0; i < SPE_MAX_RES; i++) begin
      if (2'(i) < push.cnt) begin
        mem[wr_ptr_r + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/sei_payload_extractor.sv =====
// Top level: extracts SEI payload bodies of one type from H.264 / HEVC NAL units.
//
//   port group   dir  handshake           word
//   in_*         in   in_valid/in_stall   in_t  {nal_byte, nal_end}
//   out_*        out  out_valid/out_stall out_t {data_byte, data_valid,
//                                                payload_start, payload_end, truncated}
//   cfg_*        in   cfg_wr_en           cfg_index selects, cfg_wdata carries
//
// One NAL byte per cycle while in_stall is low. A byte waits in the input register and
// is parsed in the cycle it leaves it; its results are in the output queue on the
// next cycle. A byte may yield up to three results; the queue of four drains one per
// cycle while out_stall is low, and the input register holds its byte while fewer than
// three slots would be free after this cycle's read, whatever the byte yields. Reset
// (rst_n low at a clock edge) empties both stages and restores wanted_type 4, H.264
// mode and the unit-start state.
`timescale 1ns / 1ps
module sei_payload_extractor
  import spe_pkg::*;
#(
  parameter int SIZE_BITS = SPE_SIZE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_t                       in_payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_t                      out_payload,
  input  logic                      cfg_wr_en,
  input  logic [SPE_CFG_IDX_W-1:0]  cfg_index,
  input  logic [SPE_CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  in_vld_r;
  in_t   in_word_r;
  logic  room;
  logic  go;
  push_t push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_type <= WANTED_TYPE_RST;
      cfg_r.hevc_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WANTED_TYPE: cfg_r.wanted_type <= cfg_wdata[15:0];
        REG_HEVC_MODE:   cfg_r.hevc_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // advance the held word when its results fit the queue
  assign go       = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_payload;
    end
  end

  spe_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item_go (go),
    .item    (in_word_r),
    .push    (push)
  );

  spe_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sei_payload_extractor: predicts SEI body words and checks the output.
`timescale 1ns / 1ps
module tb;
  import spe_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;

  class sei_scoreboard;
    out_t                     expected_q[$];
    out_t                     word_res[SPE_MAX_RES];
    int                       made;
    int                       errors;
    logic [15:0]              want_type;
    bit                       hevc;
    // per-unit parse state
    bit                       unit_start;
    bit                       is_sei;
    logic [1:0]               hdr_left;
    logic [1:0]               zeros;
    bit                       held3;
    phase_t                   phase;
    logic [15:0]              type_acc;
    logic [SPE_SIZE_BITS-1:0] size_acc;
    bit                       typ_match;
    bit                       body_seen;

    function new();
      errors    = 0;
      want_type = WANTED_TYPE_RST;
      hevc      = 1'b0;
      clear_unit();
    endfunction

    function void clear_unit();
      unit_start = 1'b1;
      is_sei     = 1'b0;
      hdr_left   = '0;
      zeros      = '0;
      held3      = 1'b0;
      phase      = PH_TYPE;
      type_acc   = '0;
      size_acc   = '0;
      typ_match  = 1'b0;
      body_seen  = 1'b0;
    endfunction

    function void add_result(logic [7:0] d, bit v, bit s, bit en, bit t);
      if (made < SPE_MAX_RES) begin
        word_res[made] = '{d, v, s, en, t};
        made++;
      end
    endfunction

    function void parse_rbsp(logic [7:0] b, bit last);
      logic [16:0]              tsum;
      logic [SPE_SIZE_BITS:0]   ssum;
      case (phase)
        PH_TYPE: begin
          // trailing bits close the parse
          if (b == BYTE_STOP && last && type_acc == 0) return;
          tsum = {1'b0, type_acc} + 17'(b);
          type_acc = tsum[16] ? 16'hFFFF : tsum[15:0];
          if (b != BYTE_FF) begin
            phase    = PH_SIZE;
            size_acc = '0;
          end
        end
        PH_SIZE: begin
          ssum = {1'b0, size_acc} + (SPE_SIZE_BITS+1)'(b);
          size_acc = ssum[SPE_SIZE_BITS] ? '1 : ssum[SPE_SIZE_BITS-1:0];
          if (b != BYTE_FF) begin
            if (size_acc == 0) begin
              phase    = PH_TYPE;
              type_acc = '0;
            end else begin
              phase     = PH_BODY;
              typ_match = (type_acc == want_type);
              body_seen = 1'b0;
            end
          end
        end
        default: begin
          size_acc = size_acc - SPE_SIZE_BITS'(1);
          if (typ_match) add_result(b, 1'b1, !body_seen, size_acc == 0, 1'b0);
          body_seen = 1'b1;
          if (size_acc == 0) begin
            phase     = PH_TYPE;
            type_acc  = '0;
            body_seen = 1'b0;
            typ_match = 1'b0;
          end
        end
      endcase
    endfunction

    function void note_word(in_t w);
      logic [7:0] b;
      bit         e;
      b    = w.nal_byte;
      e    = w.nal_end;
      made = 0;
      if (unit_start) begin
        unit_start = 1'b0;
        if (hevc) begin
          is_sei   = (b[6:1] == HEVC_TYPE_SEI_PRE) || (b[6:1] == HEVC_TYPE_SEI_SUFX);
          hdr_left = 2'd1;
        end else begin
          is_sei   = (b[4:0] == AVC_TYPE_SEI);
          hdr_left = 2'd0;
        end
      end else if (!is_sei) begin
      end else if (hdr_left > 0) begin
        hdr_left--;
      end else begin
        // resolve a held 0x03: keep it only if the next byte is above 0x03
        if (held3) begin
          held3 = 1'b0;
          if (b > BYTE_EPB) parse_rbsp(BYTE_EPB, 1'b0);
          zeros = '0;
        end
        if (zeros >= 2 && b == BYTE_EPB && !e) begin
          held3 = 1'b1;
        end else begin
          parse_rbsp(b, e);
          if (b == 0) zeros = (zeros >= 2) ? 2'd2 : zeros + 2'd1;
          else zeros = '0;
        end
      end
      if (e) begin
        if (is_sei && phase == PH_BODY && typ_match && size_acc != 0) begin
          if (body_seen && made > 0) begin
            word_res[made-1].payload_end = 1'b1;
            word_res[made-1].truncated   = 1'b1;
          end else begin
            add_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
          end
        end
        clear_unit();
      end
      for (int i = 0; i < made; i++) expected_q.push_back(word_res[i]);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
      if (got.data_valid !== want.data_valid)
        report_mismatch($sformatf("data_valid got %b want %b", got.data_valid,
                                  want.data_valid));
      if (got.payload_start !== want.payload_start)
        report_mismatch($sformatf("payload_start got %b want %b", got.payload_start,
                                  want.payload_start));
      if (got.payload_end !== want.payload_end)
        report_mismatch($sformatf("payload_end got %b want %b", got.payload_end,
                                  want.payload_end));
      if (got.truncated !== want.truncated)
        report_mismatch($sformatf("truncated got %b want %b", got.truncated, want.truncated));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_t                       in_payload = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_t                      out_payload;
  logic                      cfg_wr_en = 1'b0;
  logic [SPE_CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SPE_CFG_DATA_W-1:0] cfg_wdata = '0;

  sei_scoreboard sb = new();
  int            in_idle_pct = 0;
  int            out_stall_pct = 0;
  int            words_sent = 0;
  int            cycles = 0;

  sei_payload_extractor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_payload);
      if (out_valid && !out_stall) sb.check_result(out_payload);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [7:0] b, bit e);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= {b, e};
    words_sent++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_nal(input logic [7:0] nal[$]);
    for (int i = 0; i < nal.size(); i++) send_word(nal[i], i == nal.size() - 1);
  endtask

  // Hold the input until every predicted word has come back and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [SPE_CFG_IDX_W-1:0] idx, logic [SPE_CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] wanted, bit hevc);
    drain();
    write_reg(REG_WANTED_TYPE, wanted);
    sb.want_type = wanted;
    write_reg(REG_HEVC_MODE, {15'd0, hevc});
    sb.hevc = hevc;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return BYTE_EPB;
      3:       return BYTE_FF;
      4:       return BYTE_STOP;
      5:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_chain(ref logic [7:0] q[$], input int unsigned v);
    while (v >= 255) begin
      q.push_back(BYTE_FF);
      v -= 255;
    end
    q.push_back(8'(v));
  endfunction

  function automatic void add_header(ref logic [7:0] q[$], input bit sei);
    logic [5:0] ht;
    if (sb.hevc) begin
      if (sei) ht = $urandom_range(0, 1) ? HEVC_TYPE_SEI_PRE : HEVC_TYPE_SEI_SUFX;
      else ht = 6'($urandom_range(0, 38));
      q.push_back({1'($urandom_range(0, 1)), ht, 1'($urandom_range(0, 1))});
      q.push_back(8'($urandom));
    end else begin
      q.push_back({3'($urandom_range(0, 7)), sei ? AVC_TYPE_SEI : 5'($urandom_range(7, 31))});
    end
  endfunction

  // One NAL unit: mostly well-formed SEI with random content, some noise and cut units.
  function automatic void build_nal(ref logic [7:0] q[$]);
    logic [7:0]  raw[$];
    int unsigned kind, tval, sval, zrun, keep;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      q.push_back(8'($urandom));
      repeat ($urandom_range(0, 5)) q.push_back(rand_byte());
      return;
    end
    if (kind < 18) begin
      add_header(q, 1'b0);
      repeat ($urandom_range(0, 5)) q.push_back(rand_byte());
      return;
    end
    add_header(q, 1'b1);
    repeat ($urandom_range(1, 3)) begin
      if (sb.want_type <= 600 && $urandom_range(0, 1)) tval = sb.want_type;
      else tval = $urandom_range(0, 300);
      kind = $urandom_range(0, 99);
      if (kind < 85) sval = $urandom_range(0, 5);
      else if (kind < 97) sval = $urandom_range(6, 20);
      else sval = $urandom_range(255, 300);
      push_chain(raw, tval);
      push_chain(raw, sval);
      repeat (sval) raw.push_back(rand_byte());
    end
    if ($urandom_range(0, 9) < 7) raw.push_back(BYTE_STOP);
    // insert emulation prevention, skipping it now and then
    zrun = 0;
    foreach (raw[i]) begin
      if (zrun >= 2 && raw[i] <= BYTE_EPB && $urandom_range(0, 9) != 0) begin
        q.push_back(BYTE_EPB);
        zrun = 0;
      end
      q.push_back(raw[i]);
      zrun = (raw[i] == 0) ? zrun + 1 : 0;
    end
    if (q.size() > 1 && $urandom_range(0, 99) < 15) begin
      keep = $urandom_range(1, q.size() - 1);
      while (q.size() > keep) void'(q.pop_back());
    end
  endfunction

  task automatic run_random(int n_words);
    logic [7:0] nal[$];
    int         first;
    first = words_sent;
    while (words_sent - first < n_words) begin
      build_nal(nal);
      send_nal(nal);
    end
  endtask

  task automatic run_directed();
    logic [7:0] nal[$];
    // two body bytes, then trailing bits
    nal = '{8'h06, 8'h04, 8'h02, 8'hAA, 8'hBB, BYTE_STOP};
    send_nal(nal);
    // dropped escape byte, empty message, then a 0x03 after zeros on the last byte
    nal = '{8'h06, 8'h04, 8'h03, 8'h00, 8'h00, BYTE_EPB, 8'h01, 8'h00, 8'h00, BYTE_EPB};
    send_nal(nal);
    // empty body, then a body cut short after one byte
    nal = '{8'h06, 8'h05, 8'h00, 8'h04, 8'h05, 8'h11};
    send_nal(nal);
    // cut short before any body byte
    nal = '{8'h06, 8'h04, 8'h07};
    send_nal(nal);
    // not SEI, then a unit that ends in its header
    nal = '{8'h01, BYTE_FF};
    send_nal(nal);
    nal = '{8'h06};
    send_nal(nal);
  endtask

  // Type field past 65535 saturates and then matches a wanted type of 65535.
  task automatic send_type_saturation();
    logic [7:0] nal[$];
    add_header(nal, 1'b1);
    repeat (260) nal.push_back(BYTE_FF);
    nal.push_back(8'h10);
    nal.push_back(8'h03);
    repeat (3) nal.push_back(8'($urandom));
    nal.push_back(BYTE_STOP);
    send_nal(nal);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct   = 32;
    out_stall_pct = 81;
    configure(WANTED_TYPE_RST, 1'b0);
    run_directed();
    run_random(40);
    configure(16'd0, 1'b1);
    run_random(35);

    in_idle_pct   = 81;
    out_stall_pct = 32;
    configure(16'hFFFF, 1'b0);
    send_type_saturation();
    run_random(20);
    configure(16'd5, 1'b1);
    run_random(30);

    in_idle_pct   = 0;
    out_stall_pct = 0;
    configure(16'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
    run_random(30);
    configure(WANTED_TYPE_RST, 1'b0);
    run_random(25);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spe_pkg.sv
rtl/spe_parser.sv
rtl/spe_out_fifo.sv
rtl/sei_payload_extractor.sv
tb/tb.sv
